/* rtl/core/sfs_pkg.sv */
// Shared types, codes and defaults for the sprite frame stepper.
package sfs_pkg;

  // Default frame window size in pixels
  localparam int FRAME_WIDTH_DEFAULT  = 32;
  localparam int FRAME_HEIGHT_DEFAULT = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Request modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_START = 2'd1;
  localparam mode_t MODE_END   = 2'd2;

  // Animation state codes as reported on anim_state
  typedef logic [1:0] run_t;
  localparam run_t ST_READY   = 2'd0;
  localparam run_t ST_RUNNING = 2'd1;
  localparam run_t ST_PAUSED  = 2'd2;

  // Configuration register indexes
  typedef logic [CFG_INDEX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FRAME_DURATION = 3'd0;
  localparam cfg_idx_t CFG_SHEET_WIDTH    = 3'd1;
  localparam cfg_idx_t CFG_SHEET_HEIGHT   = 3'd2;
  localparam cfg_idx_t CFG_START_X        = 3'd3;
  localparam cfg_idx_t CFG_START_Y        = 3'd4;
  localparam cfg_idx_t CFG_MAX_FRAME      = 3'd5;
  localparam cfg_idx_t CFG_LOOPING        = 3'd6;
  localparam cfg_idx_t CFG_REVERSE        = 3'd7;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic add;
    logic start;
    logic rewind;
    logic step;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t req_mode;
    logic  tick_ok;
    logic  add_over;
    logic  step_last;
  } status_t;

endpackage

/* rtl/core/sfs_ctrl.sv */
// Request sequencer of the sprite frame stepper.
module sfs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  sfs_pkg::status_t sts,
  output sfs_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DISPATCH = 4'b0010,
    S_STEP     = 4'b0100,
    S_DONE     = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        case (sts.req_mode)
          sfs_pkg::MODE_TICK: begin
            if (sts.tick_ok) begin
              cmd.add = 1'b1;
              if (sts.add_over) state_next = S_STEP;
            end
          end
          sfs_pkg::MODE_START: cmd.start  = 1'b1;
          sfs_pkg::MODE_END:   cmd.rewind = 1'b1;
          default: ;
        endcase
      end
      S_STEP: begin
        // one frame duration used up per cycle
        cmd.step = 1'b1;
        if (sts.step_last) state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/sfs_datapath.sv */
// Configuration, animation state, frame advance logic and result register.
module sfs_datapath #(
  parameter int FRAME_WIDTH  = sfs_pkg::FRAME_WIDTH_DEFAULT,
  parameter int FRAME_HEIGHT = sfs_pkg::FRAME_HEIGHT_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]                     mode,
  input  logic [15:0]                    delta,
  input  sfs_pkg::cmd_t                  cmd,
  output sfs_pkg::status_t               sts,
  output logic [11:0]                    rect_x,
  output logic [11:0]                    rect_y,
  output logic [15:0]                    frame_index,
  output logic [1:0]                     anim_state
);

  localparam logic [12:0] FW = 13'(FRAME_WIDTH);
  localparam logic [12:0] FH = 13'(FRAME_HEIGHT);

  // configuration
  logic [15:0]        frame_duration;
  logic [12:0]        sheet_width;
  logic [12:0]        sheet_height;
  logic [11:0]        start_x;
  logic [11:0]        start_y;
  logic signed [16:0] max_frame;
  logic               looping;
  logic               reverse;

  // animation state
  logic signed [17:0] acc;
  logic [11:0]        pos_x;
  logic [11:0]        pos_y;
  logic [15:0]        fc;
  sfs_pkg::run_t      run_state;

  // captured request
  sfs_pkg::mode_t     req_mode;
  logic [15:0]        req_delta;

  logic signed [17:0] dur_s;
  logic signed [17:0] acc_sum;
  logic signed [17:0] acc_sub;
  logic               sub_pos;

  logic               mf_neg;
  logic [15:0]        mf_val;
  logic               at_lim;
  logic               lim_wrap;
  logic               lim_pause;
  logic [15:0]        fc_base;
  logic [11:0]        bx;
  logic [11:0]        by;
  logic               move_ok;
  logic [13:0]        fwd_x_sum;
  logic [13:0]        fwd_y_sum;
  logic               fwd_x_fit;
  logic               fwd_y_fit;
  logic [12:0]        rev_x_diff;
  logic [12:0]        rev_y_diff;
  logic [12:0]        row_x_diff;
  logic               rev_x_fit;
  logic               rev_y_fit;
  logic [11:0]        row_x;

  logic [11:0]        adv_x;
  logic [11:0]        adv_y;
  logic [15:0]        adv_fc;
  logic               adv_pause;

  assign dur_s   = signed'({2'b00, frame_duration});
  assign acc_sum = acc + signed'({2'b00, req_delta});
  assign acc_sub = acc - dur_s;
  assign sub_pos = !acc_sub[17] && (acc_sub != '0);

  // frame limit check
  assign mf_neg    = max_frame[16];
  assign mf_val    = max_frame[15:0];
  assign at_lim    = !mf_neg && (mf_val != '0) && (fc >= mf_val);
  assign lim_wrap  = at_lim && looping;
  assign lim_pause = at_lim && !looping;
  assign fc_base   = lim_wrap ? '0 : fc;
  assign bx        = lim_wrap ? start_x : pos_x;
  assign by        = lim_wrap ? start_y : pos_y;
  assign move_ok   = mf_neg || (fc_base <= mf_val);

  // window moves
  assign fwd_x_sum  = {2'b00, bx} + {1'b0, FW};
  assign fwd_y_sum  = {2'b00, by} + {1'b0, FH};
  assign fwd_x_fit  = fwd_x_sum < {1'b0, sheet_width};
  assign fwd_y_fit  = fwd_y_sum < {1'b0, sheet_height};
  assign rev_x_fit  = {1'b0, bx} >= FW;
  assign rev_y_fit  = {1'b0, by} >= FH;
  assign rev_x_diff = {1'b0, bx} - FW;
  assign rev_y_diff = {1'b0, by} - FH;
  assign row_x_diff = sheet_width - FW;
  assign row_x      = (sheet_width >= FW) ? row_x_diff[11:0] : '0;

  always_comb begin
    adv_x     = bx;
    adv_y     = by;
    adv_fc    = fc_base;
    adv_pause = lim_pause;
    if (!lim_pause && move_ok) begin
      if (!reverse) begin
        if (fwd_x_fit) begin
          adv_x = fwd_x_sum[11:0];
        end else if (fwd_y_fit) begin
          adv_y = fwd_y_sum[11:0];
          adv_x = '0;
        end else if (looping) begin
          adv_x = start_x;
          adv_y = start_y;
        end else begin
          adv_pause = 1'b1;
        end
      end else begin
        if (rev_x_fit) begin
          adv_x = rev_x_diff[11:0];
        end else if (rev_y_fit) begin
          adv_y = rev_y_diff[11:0];
          adv_x = row_x;
        end else if (looping) begin
          adv_x = start_x;
          adv_y = start_y;
        end else begin
          adv_pause = 1'b1;
        end
      end
      if (!adv_pause) adv_fc = fc_base + 16'd1;
    end
  end

  assign sts.req_mode  = req_mode;
  assign sts.tick_ok   = (run_state == sfs_pkg::ST_RUNNING) && (frame_duration != '0);
  assign sts.add_over  = acc_sum > dur_s;
  assign sts.step_last = !sub_pos || adv_pause;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_duration <= '0;
      sheet_width    <= 13'd256;
      sheet_height   <= 13'd256;
      start_x        <= '0;
      start_y        <= '0;
      max_frame      <= -17'sd1;
      looping        <= 1'b1;
      reverse        <= 1'b0;
      acc            <= '0;
      pos_x          <= '0;
      pos_y          <= '0;
      fc             <= '0;
      run_state      <= sfs_pkg::ST_READY;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfs_pkg::CFG_FRAME_DURATION: frame_duration <= cfg_data[15:0];
          sfs_pkg::CFG_SHEET_WIDTH:    sheet_width    <= cfg_data[12:0];
          sfs_pkg::CFG_SHEET_HEIGHT:   sheet_height   <= cfg_data[12:0];
          sfs_pkg::CFG_START_X:        start_x        <= cfg_data[11:0];
          sfs_pkg::CFG_START_Y:        start_y        <= cfg_data[11:0];
          sfs_pkg::CFG_MAX_FRAME:      max_frame      <= signed'(cfg_data[16:0]);
          sfs_pkg::CFG_LOOPING:        looping        <= cfg_data[0];
          sfs_pkg::CFG_REVERSE:        reverse        <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.add) acc <= acc_sum;
      if (cmd.start && (frame_duration != '0) && (run_state != sfs_pkg::ST_RUNNING)) begin
        run_state <= sfs_pkg::ST_RUNNING;
      end
      if (cmd.rewind) begin
        acc       <= '0;
        pos_x     <= start_x;
        pos_y     <= start_y;
        fc        <= '0;
        run_state <= sfs_pkg::ST_READY;
      end
      if (cmd.step) begin
        // keep the remainder even when this subtraction ends the tick
        acc <= acc_sub;
        if (sub_pos) begin
          pos_x <= adv_x;
          pos_y <= adv_y;
          fc    <= adv_fc;
          if (adv_pause) run_state <= sfs_pkg::ST_PAUSED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode  <= mode;
      req_delta <= delta;
    end
    if (cmd.load_out) begin
      rect_x      <= pos_x;
      rect_y      <= pos_y;
      frame_index <= fc;
      anim_state  <= run_state;
    end
  end

endmodule

/* rtl/core/sprite_frame_stepper.sv */
// Top level of the sprite frame stepper.
// Takes one request at a time and answers each with one result: the window
// position, frame count and animation state after the request. An accepted
// request is captured, then dispatched: a start, an end, or a tick that crosses
// no frame boundary goes straight to loading its result, while a tick that
// crosses boundaries first runs the subtract-and-advance loop in the datapath,
// which subtracts one frame duration from the time accumulator per step and
// advances the window, until the remainder is no longer positive or the
// animation pauses. The result is loaded once the output register is free,
// and only then is the next request taken.
// While the output register holds an untaken result, a new request is still
// accepted; its result waits in the sequencer until the register frees up.
module sprite_frame_stepper #(
  parameter int FRAME_WIDTH  = sfs_pkg::FRAME_WIDTH_DEFAULT,
  parameter int FRAME_HEIGHT = sfs_pkg::FRAME_HEIGHT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      mode,
  input  logic [15:0]                     delta,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [11:0]                     rect_x,
  output logic [11:0]                     rect_y,
  output logic [15:0]                     frame_index,
  output logic [1:0]                      anim_state
);

  sfs_pkg::cmd_t    cmd;
  sfs_pkg::status_t sts;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfs_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .delta       (delta),
    .cmd         (cmd),
    .sts         (sts),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .frame_index (frame_index),
    .anim_state  (anim_state)
  );

endmodule

/* rtl/core/sfs_checker.sv */
// Port-level checker for the sprite frame stepper, bound to the top level.
module sfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] rect_x,
  input logic [11:0] rect_y,
  input logic [15:0] frame_index,
  input logic [1:0]  anim_state
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // requests accepted whose results are not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 2'd0))
    else $error("result shown with no request outstanding");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("second request taken while one is in progress");

  a_ready_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (anim_state == sfs_pkg::ST_READY)) |-> (frame_index == 16'd0))
    else $error("ready state reported with a nonzero frame count");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(rect_x) && $stable(rect_y) && $stable(frame_index)))
    else $error("stalled result changed");

endmodule

bind sprite_frame_stepper sfs_checker u_sfs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .rect_x      (rect_x),
  .rect_y      (rect_y),
  .frame_index (frame_index),
  .anim_state  (anim_state)
);
